// ----- sv/mfuw_pkg.sv -----
// ----------------------------------------------------------------------------
// Motor feedback unwrap package
// Payload types, status types and constants shared by the feedback decoder.
// ----------------------------------------------------------------------------
package mfuw_pkg;

   localparam logic              KIND_FRAME  = 1'b0;
   localparam logic              KIND_TICK   = 1'b1;
   localparam logic signed [16:0] WRAP_LIMIT = 17'sd4095;
   localparam logic signed [16:0] TURN_SPAN  = 17'sd8191;
   localparam logic [15:0]       LIMIT_RESET = 16'd100;

   typedef struct packed {
      logic        kind;
      logic [55:0] frame_data;
   } req_payload_type;

   typedef struct packed {
      logic [15:0]        angle_word;
      logic signed [31:0] turn_count_sum;
      logic signed [15:0] speed_rpm;
      logic signed [15:0] current_word;
      logic [7:0]         temperature;
      logic               online;
      logic [15:0]        silent_ticks;
   } rsp_payload_type;

   typedef struct packed {
      logic main_valid;
      logic skid_valid;
   } buf_status_type;

endpackage

// ----- sv/mfuw_if.sv -----
// ----------------------------------------------------------------------------
// Motor feedback unwrap channel interfaces
// Valid/ready channels for feedback requests and status responses.
// ----------------------------------------------------------------------------
interface mfuw_req_if import mfuw_pkg::*;;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mfuw_rsp_if import mfuw_pkg::*;;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/mfuw_core.sv -----
// ----------------------------------------------------------------------------
// Motor feedback unwrap core
// Holds the decoded feedback and watchdog state and forms the next status.
// ----------------------------------------------------------------------------
module mfuw_core import mfuw_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_payload_type req,
   input  logic [15:0]     limit,
   output rsp_payload_type result
);

   logic [15:0] last_angle_ff, last_angle_in;
   logic [31:0] position_sum_ff, position_sum_in;
   logic [15:0] speed_hold_ff, speed_hold_in;
   logic [15:0] current_hold_ff, current_hold_in;
   logic [7:0]  temperature_hold_ff, temperature_hold_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic        online_ff, online_in;

   logic [15:0]        angle;
   logic [15:0]        raw_diff;
   logic signed [16:0] raw_ext;
   logic signed [16:0] diff;
   logic [15:0]        tick_inc;

   always_comb begin
      angle    = req.frame_data[55:40];
      raw_diff = angle - last_angle_ff;
      raw_ext  = signed'({raw_diff[15], raw_diff});
      if (last_angle_ff == 16'd0 && position_sum_ff == 32'd0) begin
         diff = 17'sd0;
      end else if (raw_ext > WRAP_LIMIT) begin
         diff = raw_ext - TURN_SPAN;
      end else if (raw_ext < -WRAP_LIMIT) begin
         diff = raw_ext + TURN_SPAN;
      end else begin
         diff = raw_ext;
      end
      tick_inc = tick_count_ff + 16'd1;

      last_angle_in       = last_angle_ff;
      position_sum_in     = position_sum_ff;
      speed_hold_in       = speed_hold_ff;
      current_hold_in     = current_hold_ff;
      temperature_hold_in = temperature_hold_ff;
      tick_count_in       = tick_count_ff;
      online_in           = online_ff;

      if (req.kind == KIND_FRAME) begin
         last_angle_in       = angle;
         position_sum_in     = position_sum_ff + {{15{diff[16]}}, diff};
         speed_hold_in       = req.frame_data[39:24];
         current_hold_in     = req.frame_data[23:8];
         temperature_hold_in = req.frame_data[7:0];
         tick_count_in       = 16'd0;
      end else if (tick_inc > limit) begin
         tick_count_in = limit;
         online_in     = 1'b0;
      end else begin
         tick_count_in = tick_inc;
         online_in     = 1'b1;
      end

      result.angle_word     = last_angle_in;
      result.turn_count_sum = signed'(position_sum_in);
      result.speed_rpm      = signed'(speed_hold_in);
      result.current_word   = signed'(current_hold_in);
      result.temperature    = temperature_hold_in;
      result.online         = online_in;
      result.silent_ticks   = tick_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_angle_ff       <= 16'd0;
         position_sum_ff     <= 32'd0;
         speed_hold_ff       <= 16'd0;
         current_hold_ff     <= 16'd0;
         temperature_hold_ff <= 8'd0;
         tick_count_ff       <= 16'd0;
         online_ff           <= 1'b0;
      end else if (accept) begin
         last_angle_ff       <= last_angle_in;
         position_sum_ff     <= position_sum_in;
         speed_hold_ff       <= speed_hold_in;
         current_hold_ff     <= current_hold_in;
         temperature_hold_ff <= temperature_hold_in;
         tick_count_ff       <= tick_count_in;
         online_ff           <= online_in;
      end
   end

endmodule

// ----- sv/mfuw_out_buf.sv -----
// ----------------------------------------------------------------------------
// Motor feedback unwrap output buffer
// Result register with a skid stage so the input side sees a registered ready.
// ----------------------------------------------------------------------------
module mfuw_out_buf import mfuw_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  rsp_payload_type in_data,
   output logic            in_ready,
   output buf_status_type  status,
   mfuw_rsp_if.source      rsp_chan
);

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type main_data_ff, main_data_in;
   rsp_payload_type skid_data_ff, skid_data_in;
   logic            push;
   logic            pop;

   assign in_ready          = !skid_valid_ff;
   assign status.main_valid = main_valid_ff;
   assign status.skid_valid = skid_valid_ff;
   assign rsp_chan.valid    = main_valid_ff;
   assign rsp_chan.payload  = main_data_ff;

   always_comb begin
      push          = in_valid && in_ready;
      pop           = main_valid_ff && rsp_chan.ready;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = in_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ----- sv/motor_feedback_unwrap_watchdog.sv -----
// ----------------------------------------------------------------------------
// Motor feedback unwrap and offline watchdog
// Decodes feedback frames, unwraps the encoder angle into a multi-turn sum
// and tracks ticks without a frame to flag the motor offline.
//
//   channel   direction  protocol       payload
//   req_chan  in         valid/ready    kind, frame_data
//   rsp_chan  out        valid/ready    angle, sum, speed, current, temp, status
//   csr_*     in         write enable   offline_limit
//
// One transaction is accepted per cycle while req_chan.ready is high. Its
// response is registered in the result register, or in the skid stage while
// that is stalled; req_chan.ready drops only when both stages are full. The
// state update is formed combinationally from the held registers. Reset is
// synchronous and restores a limit of 100, zero core state and empty stages.
// ----------------------------------------------------------------------------
module motor_feedback_unwrap_watchdog import mfuw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mfuw_req_if.sink    req_chan,
   mfuw_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0]     offline_limit_ff;
   logic            accept;
   logic            buf_ready;
   rsp_payload_type core_result;
   buf_status_type  buf_status;

   assign req_chan.ready = buf_ready;
   assign accept         = req_chan.valid && buf_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         offline_limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         offline_limit_ff <= csr_wr_data;
      end
   end

   mfuw_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_chan.payload),
      .limit  (offline_limit_ff),
      .result (core_result)
   );

   mfuw_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_data  (core_result),
      .in_ready (buf_ready),
      .status   (buf_status),
      .rsp_chan (rsp_chan)
   );

   a_tick_bounded: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.payload.kind == KIND_TICK
      |-> core_result.silent_ticks <= offline_limit_ff)
      else $error("tick count exceeds the offline limit");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.payload.kind == KIND_FRAME
      |-> core_result.silent_ticks == 16'd0)
      else $error("frame did not clear the tick count");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      buf_status.skid_valid |-> buf_status.main_valid)
      else $error("skid stage holds data while the result register is empty");

   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_chan.valid)
      else $error("accepted transaction produced no response");

endmodule

// ----- sim/motor_feedback_unwrap_watchdog_test.sv -----
// ----------------------------------------------------------------------------
// Motor feedback unwrap and offline watchdog testbench
// Drives feedback frames and ticks into the block under random valid and
// ready gaps. It predicts the decoded fields, the unwrapped multi-turn sum
// and the watchdog status of every transaction, then compares each response
// field by field in order. The offline limit is rewritten between phases.
// ----------------------------------------------------------------------------
module motor_feedback_unwrap_watchdog_test;
   import mfuw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   mfuw_req_if req_chan_if ();
   mfuw_rsp_if rsp_chan_if ();

   motor_feedback_unwrap_watchdog uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan_if),
      .rsp_chan    (rsp_chan_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predicted motor state.
   logic [15:0] limit_cfg;
   logic [15:0] angle_held;
   logic [31:0] position_held;
   logic [15:0] speed_held;
   logic [15:0] current_held;
   logic [7:0]  temperature_held;
   logic [15:0] silent_count;
   logic        online_held;

   rsp_payload_type pending_status[$];
   int              mismatches = 0;
   bit              steady = 0;
   int              rsp_hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < 50) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   function automatic rsp_payload_type predict_motor_status(input req_payload_type item);
      rsp_payload_type status;
      logic [15:0]     angle;
      logic [15:0]     raw;
      int              step;

      if (item.kind == KIND_FRAME) begin
         angle = item.frame_data[55:40];
         if (angle_held == 16'd0 && position_held == 32'd0) begin
            step = 0;
         end else begin
            raw = angle - angle_held;
            step = $signed(raw);
         end
         if (step > WRAP_LIMIT || step < -WRAP_LIMIT) begin
            if (step >= 0) begin
               step = step - TURN_SPAN;
            end else begin
               step = step + TURN_SPAN;
            end
         end
         position_held = position_held + 32'(step);
         angle_held = angle;
         speed_held = item.frame_data[39:24];
         current_held = item.frame_data[23:8];
         temperature_held = item.frame_data[7:0];
         silent_count = 16'd0;
      end else begin
         silent_count = silent_count + 16'd1;
         if (silent_count > limit_cfg) begin
            silent_count = limit_cfg;
            online_held = 1'b0;
         end else begin
            online_held = 1'b1;
         end
      end
      status.angle_word = angle_held;
      status.turn_count_sum = position_held;
      status.speed_rpm = speed_held;
      status.current_word = current_held;
      status.temperature = temperature_held;
      status.online = online_held;
      status.silent_ticks = silent_count;
      return status;
   endfunction

   initial begin
      rsp_chan_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_chan_if.ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (steady) begin
            rsp_chan_if.ready <= 1'b1;
         end else begin
            rsp_chan_if.ready <= ($urandom_range(99) >= 28);
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type got;
      rsp_payload_type want;
      if (!reset && rsp_chan_if.valid && rsp_chan_if.ready) begin
         got = rsp_chan_if.payload;
         if (pending_status.size() == 0) begin
            report_mismatch("response with no transaction waiting");
         end else begin
            want = pending_status.pop_front();
            check_field("angle_word", got.angle_word, want.angle_word);
            check_field("turn_count_sum", got.turn_count_sum, want.turn_count_sum);
            check_field("speed_rpm", got.speed_rpm, want.speed_rpm);
            check_field("current_word", got.current_word, want.current_word);
            check_field("temperature", got.temperature, want.temperature);
            check_field("online", got.online, want.online);
            check_field("silent_ticks", got.silent_ticks, want.silent_ticks);
         end
      end
   end

   task automatic send_feedback(input req_payload_type item);
      if (!steady && $urandom_range(99) < 28) begin
         req_chan_if.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_chan_if.valid <= 1'b1;
      req_chan_if.payload <= item;
      @(posedge clock);
      while (!req_chan_if.ready) @(posedge clock);
      pending_status.push_back(predict_motor_status(item));
   endtask

   task automatic stop_feedback();
      req_chan_if.valid <= 1'b0;
   endtask

   task automatic wait_status_drain();
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   task automatic write_offline_limit(input logic [15:0] value);
      stop_feedback();
      wait_status_drain();
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_cfg = value;
   endtask

   function automatic req_payload_type make_frame(input logic [15:0] angle);
      req_payload_type item;
      logic [63:0]     bits;
      bits = {$urandom(), $urandom()};
      item.kind = KIND_FRAME;
      item.frame_data = {angle, bits[39:0]};
      return item;
   endfunction

   function automatic req_payload_type make_tick();
      req_payload_type item;
      logic [63:0]     bits;
      bits = {$urandom(), $urandom()};
      item.kind = KIND_TICK;
      item.frame_data = bits[55:0];
      return item;
   endfunction

   task automatic send_ticks(input int count);
      repeat (count) send_feedback(make_tick());
   endtask

   task automatic test_frame_decode();
      req_payload_type item;
      item.kind = KIND_FRAME;
      item.frame_data = 56'h0;
      send_feedback(item);
      item.frame_data = 56'hFF_FFFF_FFFF_FFFF;
      send_feedback(item);
      item.frame_data = 56'h80_0080_0080_0080;
      send_feedback(item);
      item.frame_data = 56'h7F_FF7F_FF7F_FF7F;
      send_feedback(item);
      item.kind = KIND_TICK;
      item.frame_data = 56'hFF_FFFF_FFFF_FFFF;
      send_feedback(item);
   endtask

   task automatic test_angle_unwrap();
      logic [15:0] angles [12] = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h1000,
                                   16'h0001, 16'h1000, 16'h8001, 16'h0001, 16'h0000,
                                   16'hF001, 16'hE000};
      write_offline_limit(LIMIT_RESET);
      angle_held = angle_held;
      stop_feedback();
      wait_status_drain();
      foreach (angles[i]) send_feedback(make_frame(angles[i]));
   endtask

   task automatic test_default_limit();
      send_ticks(102);
      send_feedback(make_frame(16'h1234));
      send_ticks(2);
   endtask

   task automatic test_watchdog_limit();
      write_offline_limit(16'd1);
      send_ticks(3);
      send_feedback(make_frame(16'h2345));
      send_ticks(2);
   endtask

   task automatic test_backpressure();
      write_offline_limit(16'd5);
      steady = 1;
      rsp_hold_cycles = 60;
      repeat (24) begin
         if ($urandom_range(1)) send_feedback(make_tick());
         else send_feedback(make_frame(16'($urandom())));
      end
      steady = 0;
      stop_feedback();
      wait_status_drain();
   endtask

   task automatic test_random_traffic();
      logic [15:0] limits [6] = '{16'd1, 16'd2, 16'd3, 16'd12, 16'd100, 16'd65534};
      int          offsets [8] = '{4095, 4096, 8191, -4095, -4096, -8191, 32767, -32768};
      int          sent;
      int          pick;
      int          burst;
      logic [15:0] angle;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0) write_offline_limit(16'd1);
         else if (phase == 1) write_offline_limit(16'd65534);
         else if (phase == 2) write_offline_limit(16'($urandom_range(1, 65534)));
         else write_offline_limit(limits[$urandom_range(5)]);
         steady = (phase == 4);
         sent = 0;
         while (sent < 100) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
               burst = $urandom_range(1, (limit_cfg < 120) ? limit_cfg + 2 : 120);
               send_ticks(burst);
               sent += burst;
            end else if (pick < 50) begin
               send_feedback(make_tick());
               sent++;
            end else begin
               pick = $urandom_range(9);
               if (pick < 4) angle = angle_held + 16'(int'($urandom_range(600)) - 300);
               else if (pick < 6) angle = angle_held + 16'(offsets[$urandom_range(7)]);
               else angle = 16'($urandom());
               send_feedback(make_frame(angle));
               sent++;
            end
         end
      end
      steady = 0;
   endtask

   task automatic test_counter_ceiling();
      write_offline_limit(16'd250);
      steady = 1;
      send_ticks(252);
      send_feedback(make_frame(16'($urandom())));
      send_ticks(2);
      steady = 0;
   endtask

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 16'd0;
      req_chan_if.valid <= 1'b0;
      req_chan_if.payload <= '0;
      limit_cfg = LIMIT_RESET;
      angle_held = 16'd0;
      position_held = 32'd0;
      speed_held = 16'd0;
      current_held = 16'd0;
      temperature_held = 8'd0;
      silent_count = 16'd0;
      online_held = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_frame_decode();
      test_default_limit();
      test_angle_unwrap();
      test_watchdog_limit();
      test_backpressure();
      test_random_traffic();
      test_counter_ceiling();

      stop_feedback();
      wait_status_drain();
      repeat (10) @(posedge clock);
      if (pending_status.size() != 0) begin
         report_mismatch("expected responses never arrived");
      end
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
